### rtl/core/wps_pkg.sv
// wps_pkg: shared types and constants of the wave pcm16 stream parser
// used by wps_front, wps_queue, wps_back and the top level; no dependencies
package wps_pkg;

  typedef enum logic [2:0] {
    PH_FILEHDR,
    PH_CHUNKHDR,
    PH_BODY,
    PH_PAD,
    PH_HALT
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_SHORT_FMT = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;

  // magic words, first file byte in the low lane
  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA   = 32'h6174_6164;

  localparam logic [3:0]  HDR_LAST     = 4'd11;
  localparam logic [2:0]  CHDR_LAST    = 3'd7;
  localparam logic [4:0]  OFFSET_MAX   = 5'd31;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] FORMAT_PCM   = 16'd1;
  localparam logic [15:0] CHANNELS_ONE = 16'd1;
  localparam logic [15:0] BITS_PCM16   = 16'd16;
  localparam logic [31:0] RATE_RESET   = 32'd16000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // results caused by one byte: an optional sample, then an optional status
  typedef struct packed {
    logic        has_sample;
    logic [15:0] sample;
    logic        chunk_start;
    logic        has_status;
    logic [2:0]  status;
  } rec_t;

endpackage

### rtl/core/wps_front.sv
// wps_front: byte parser, walks the riff header and chunks and classifies each byte
// depends on wps_pkg
module wps_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_file,
  input  logic [31:0]       required_rate,
  output logic              rec_valid,
  output wps_pkg::rec_t     rec
);

  wps_pkg::phase_t phase, phase_next;
  logic [3:0]  header_position, header_position_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [4:0]  chunk_offset, chunk_offset_next;
  logic        pad_pending, pad_pending_next;
  logic [15:0] fmt_format, fmt_format_next;
  logic [15:0] fmt_channels, fmt_channels_next;
  logic [31:0] fmt_rate, fmt_rate_next;
  logic [15:0] fmt_bits, fmt_bits_next;
  logic        data_seen, data_seen_next;
  logic        data_size_odd, data_size_odd_next;
  logic [8:0]  low_byte_hold, low_byte_hold_next;

  logic [2:0]  err;
  logic [31:0] rem_full;
  logic [31:0] rem_dec;
  logic [7:0]  magic_byte;
  logic        mismatch;
  logic        format_ok;

  always_comb begin
    phase_next           = phase;
    header_position_next = header_position;
    chunk_tag_next       = chunk_tag;
    chunk_remaining_next = chunk_remaining;
    chunk_offset_next    = chunk_offset;
    pad_pending_next     = pad_pending;
    fmt_format_next      = fmt_format;
    fmt_channels_next    = fmt_channels;
    fmt_rate_next        = fmt_rate;
    fmt_bits_next        = fmt_bits;
    data_seen_next       = data_seen;
    data_size_odd_next   = data_size_odd;
    low_byte_hold_next   = low_byte_hold;
    err                  = wps_pkg::ST_OK;
    rec                  = '0;
    rem_full             = {data_byte, chunk_remaining[23:0]};
    rem_dec              = chunk_remaining - 32'd1;
    magic_byte           = header_position[3]
                           ? wps_pkg::MAGIC_WAVE[{header_position[1:0], 3'b000} +: 8]
                           : wps_pkg::MAGIC_RIFF[{header_position[1:0], 3'b000} +: 8];
    mismatch             = 1'b0;

    case (phase)
      wps_pkg::PH_FILEHDR: begin
        mismatch = ((header_position[3:2] == 2'd0) || (header_position[3:2] == 2'd2))
                   && (data_byte != magic_byte);
        if (mismatch) begin
          err = wps_pkg::ST_NOT_WAVE;
        end else if (header_position == wps_pkg::HDR_LAST) begin
          header_position_next = '0;
          phase_next           = wps_pkg::PH_CHUNKHDR;
        end else begin
          header_position_next = header_position + 4'd1;
          if (end_of_file) begin
            err = wps_pkg::ST_NOT_WAVE;
          end
        end
      end
      wps_pkg::PH_CHUNKHDR: begin
        case (chunk_offset[2:0])
          3'd0, 3'd1, 3'd2, 3'd3: chunk_tag_next = {data_byte, chunk_tag[31:8]};
          3'd4: chunk_remaining_next[7:0]   = data_byte;
          3'd5: chunk_remaining_next[15:8]  = data_byte;
          3'd6: chunk_remaining_next[23:16] = data_byte;
          3'd7: chunk_remaining_next[31:24] = data_byte;
          default: chunk_tag_next = chunk_tag;
        endcase
        if (chunk_offset[2:0] == wps_pkg::CHDR_LAST) begin
          chunk_offset_next = '0;
          pad_pending_next  = rem_full[0];
          if (end_of_file && (rem_full != '0)) begin
            err = wps_pkg::ST_TRUNCATED;
          end else if ((chunk_tag == wps_pkg::TAG_FMT) && (rem_full < wps_pkg::FMT_MIN_SIZE)) begin
            err = wps_pkg::ST_SHORT_FMT;
          end else begin
            if (chunk_tag == wps_pkg::TAG_DATA) begin
              data_seen_next     = 1'b1;
              data_size_odd_next = rem_full[0];
            end
            low_byte_hold_next = '0;
            phase_next = (rem_full != '0) ? wps_pkg::PH_BODY : wps_pkg::PH_CHUNKHDR;
          end
        end else begin
          chunk_offset_next = chunk_offset + 5'd1;
        end
      end
      wps_pkg::PH_BODY: begin
        if (chunk_tag == wps_pkg::TAG_FMT) begin
          case (chunk_offset)
            5'd0:  fmt_format_next[7:0]    = data_byte;
            5'd1:  fmt_format_next[15:8]   = data_byte;
            5'd2:  fmt_channels_next[7:0]  = data_byte;
            5'd3:  fmt_channels_next[15:8] = data_byte;
            5'd4:  fmt_rate_next[7:0]      = data_byte;
            5'd5:  fmt_rate_next[15:8]     = data_byte;
            5'd6:  fmt_rate_next[23:16]    = data_byte;
            5'd7:  fmt_rate_next[31:24]    = data_byte;
            5'd14: fmt_bits_next[7:0]      = data_byte;
            5'd15: fmt_bits_next[15:8]     = data_byte;
            default: fmt_format_next = fmt_format;
          endcase
        end else if (chunk_tag == wps_pkg::TAG_DATA) begin
          if (low_byte_hold[8]) begin
            rec.has_sample     = 1'b1;
            rec.sample         = {data_byte, low_byte_hold[7:0]};
            rec.chunk_start    = (chunk_offset == 5'd1);
            low_byte_hold_next = '0;
          end else begin
            low_byte_hold_next = {1'b1, data_byte};
          end
        end
        if (chunk_offset != wps_pkg::OFFSET_MAX) begin
          chunk_offset_next = chunk_offset + 5'd1;
        end
        chunk_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          low_byte_hold_next = '0;
          chunk_offset_next  = '0;
          phase_next = pad_pending ? wps_pkg::PH_PAD : wps_pkg::PH_CHUNKHDR;
        end else if (end_of_file) begin
          err = wps_pkg::ST_TRUNCATED;
        end
      end
      wps_pkg::PH_PAD: begin
        pad_pending_next = 1'b0;
        phase_next       = wps_pkg::PH_CHUNKHDR;
      end
      wps_pkg::PH_HALT: begin
        phase_next = wps_pkg::PH_HALT;
      end
      default: begin
        phase_next = wps_pkg::PH_HALT;
      end
    endcase

    format_ok = (fmt_format_next == wps_pkg::FORMAT_PCM)
                && (fmt_channels_next == wps_pkg::CHANNELS_ONE)
                && (fmt_rate_next == required_rate)
                && (fmt_bits_next == wps_pkg::BITS_PCM16)
                && data_seen_next && !data_size_odd_next;

    if (err != wps_pkg::ST_OK) begin
      phase_next     = wps_pkg::PH_HALT;
      rec.has_status = 1'b1;
      rec.status     = err;
    end else if (end_of_file && (phase != wps_pkg::PH_HALT)) begin
      rec.has_status = 1'b1;
      rec.status     = format_ok ? wps_pkg::ST_OK : wps_pkg::ST_MISMATCH;
    end
    rec_valid = accept && (rec.has_sample || rec.has_status);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_file)) begin
      phase           <= wps_pkg::PH_FILEHDR;
      header_position <= '0;
      chunk_tag       <= '0;
      chunk_remaining <= '0;
      chunk_offset    <= '0;
      pad_pending     <= 1'b0;
      fmt_format      <= '0;
      fmt_channels    <= '0;
      fmt_rate        <= '0;
      fmt_bits        <= '0;
      data_seen       <= 1'b0;
      data_size_odd   <= 1'b0;
      low_byte_hold   <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      chunk_tag       <= chunk_tag_next;
      chunk_remaining <= chunk_remaining_next;
      chunk_offset    <= chunk_offset_next;
      pad_pending     <= pad_pending_next;
      fmt_format      <= fmt_format_next;
      fmt_channels    <= fmt_channels_next;
      fmt_rate        <= fmt_rate_next;
      fmt_bits        <= fmt_bits_next;
      data_seen       <= data_seen_next;
      data_size_odd   <= data_size_odd_next;
      low_byte_hold   <= low_byte_hold_next;
    end
  end

endmodule

### rtl/core/wps_queue.sv
// wps_queue: short register queue of result records between parser and output stage
// depends on wps_pkg
module wps_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wps_pkg::rec_t push_rec,
  input  logic          pop,
  output wps_pkg::rec_t head,
  output logic          empty,
  output logic          full
);

  wps_pkg::rec_t entries [wps_pkg::QUEUE_DEPTH];
  logic [wps_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [wps_pkg::QCNT_W-1:0] count;
  logic do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == wps_pkg::QCNT_W'(wps_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  function automatic logic [wps_pkg::QPTR_W-1:0] bump(input logic [wps_pkg::QPTR_W-1:0] p);
    return (p == wps_pkg::QPTR_W'(wps_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

### rtl/core/wps_back.sv
// wps_back: output register, presents a record's sample and then its status
// depends on wps_pkg
module wps_back (
  input  logic               clk,
  input  logic               rst,
  input  wps_pkg::rec_t      q_head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic               kind,
  output logic signed [15:0] sample_q15,
  output logic               chunk_start,
  output logic [2:0]         status,
  output logic               last
);

  wps_pkg::rec_t cur;
  logic cur_valid;
  logic taken, finishing, load;

  assign taken     = pop && cur_valid;
  // sample shown first; a record holding both stays for a second transfer
  assign finishing = taken && !(cur.has_sample && cur.has_status);
  assign load      = !cur_valid || finishing;
  assign q_pop     = load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= !q_empty;
    end
    if (load) begin
      cur <= q_head;
    end else if (taken) begin
      cur.has_sample <= 1'b0;
    end
  end

  assign empty       = !cur_valid;
  assign kind        = !cur.has_sample;
  assign sample_q15  = cur.has_sample ? cur.sample : '0;
  assign chunk_start = cur.has_sample && cur.chunk_start;
  assign status      = cur.has_sample ? wps_pkg::ST_OK : cur.status;
  assign last        = !cur.has_sample;

endmodule

### rtl/core/wav_pcm16_stream_parser_core.sv
// wav_pcm16_stream_parser_core: top level of the riff/wave pcm16 stream parser
// depends on wps_pkg, wps_front, wps_queue, wps_back
//
// One file byte is taken per clock while full is low; the parser checks the riff and
// wave magic, walks chunks with their sizes and pad bytes, captures the fmt fields and
// turns each byte pair of a data chunk into a signed Q1.15 sample that passes the queue
// and output register. The final byte gives one status result with last set, unless an
// error gave one first; an error gives its status and later bytes are dropped. A byte
// causes at most one queue record, so the input side runs at one byte per cycle while
// full is low; the output register delivers one result per cycle while pop is high,
// sample before status. A four-record queue lets both sides stall on their own. The rate
// register may be written only while the block is idle; after reset it reads 16000.
module wav_pcm16_stream_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  output logic               empty,
  input  logic               pop,
  output logic               kind,
  output logic signed [15:0] sample_q15,
  output logic               chunk_start,
  output logic [2:0]         status,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        required_rate
);

  logic [31:0]   rate_reg;
  logic          accept;
  logic          q_push, q_pop, q_empty, q_full;
  wps_pkg::rec_t front_rec, q_head;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg <= wps_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_reg <= required_rate;
    end
  end

  wps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_file   (end_of_file),
    .required_rate (rate_reg),
    .rec_valid     (q_push),
    .rec           (front_rec)
  );

  wps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (front_rec),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  wps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .kind        (kind),
    .sample_q15  (sample_q15),
    .chunk_start (chunk_start),
    .status      (status),
    .last        (last)
  );

  // parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("record pushed into full queue");

  // nothing appears on the result side without a record behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (q_empty && empty && !q_push) |=> empty)
    else $error("result appeared without a queued record");

  // the final result of a file closes the output register when nothing is queued
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && last && q_empty) |=> empty)
    else $error("result side not empty after last transfer");

endmodule
